// File: hdl/i2af_pkg.sv
// Shared types, codes and helpers of the integer to ASCII formatter.
`default_nettype none
package i2af_pkg;

  // Conversion modes carried in the request opcode
  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_PCT  = 3'd1,
    OP_PTR  = 3'd2,
    OP_SDEC = 3'd3,
    OP_UDEC = 3'd4,
    OP_HEXL = 3'd5,
    OP_HEXU = 3'd6
  } op_t;

  // Request and result payloads
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_HEX,
    S_DEC_MUL,
    S_DEC_DIV,
    S_PRE_LEAD,
    S_PRE_MARK,
    S_DIGITS
  } state_t;

  // What the datapath registers for the result port this cycle
  typedef enum logic [2:0] {
    EM_NONE,
    EM_SINGLE,
    EM_LEAD,
    EM_MARK,
    EM_DIGIT
  } emit_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;
    logic  hex_step;
    logic  mul_step;
    logic  dec_step;
    emit_t emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hex_last;
    logic dec_last;
    logic neg;
    logic cnt_one;
  } sts_t;

  // Digit buffer sizing: 16 hex digits of a pointer at most
  localparam int DIG_DEPTH = 16;
  localparam int DIG_IW    = $clog2(DIG_DEPTH);
  localparam int CNT_W     = DIG_IW + 1;

  // Reciprocal of ten: q = (v * RECIP10) >> RECIP_SHIFT is exact for 32-bit v
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUOT_W      = 64 - RECIP_SHIFT;

  // ASCII codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Map one digit to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CH_UPPER_A + {4'd0, d - 4'd10};
    end else begin
      ch = CH_LOWER_A + {4'd0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: hdl/i2af_ctrl.sv
// Controller state machine of the integer to ASCII formatter.
`default_nettype none
module i2af_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [2:0]    opcode,
  input  wire i2af_pkg::sts_t sts,
  output i2af_pkg::cmd_t     cmd,
  output logic               busy
);
  import i2af_pkg::*;

  state_t state, state_next;
  op_t    op_in;

  assign op_in = op_t'(opcode);
  assign busy  = (state != S_IDLE);

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence conversion, single-character, prefix and digit emission
  always_comb begin
    state_next = state;
    cmd        = '{load: 1'b0, hex_step: 1'b0, mul_step: 1'b0,
                   dec_step: 1'b0, emit: EM_NONE};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (op_in)
            OP_CHAR, OP_PCT:          state_next = S_SINGLE;
            OP_PTR, OP_HEXL, OP_HEXU: state_next = S_HEX;
            OP_SDEC, OP_UDEC:         state_next = S_DEC_MUL;
            default:                  state_next = S_IDLE;
          endcase
        end
      end
      S_SINGLE: begin
        cmd.emit   = EM_SINGLE;
        state_next = S_IDLE;
      end
      S_HEX: begin
        cmd.hex_step = 1'b1;
        if (sts.hex_last) begin
          state_next = sts.neg ? S_PRE_LEAD : S_DIGITS;
        end
      end
      S_DEC_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = S_DEC_DIV;
      end
      S_DEC_DIV: begin
        cmd.dec_step = 1'b1;
        if (sts.dec_last) begin
          state_next = sts.neg ? S_PRE_MARK : S_DIGITS;
        end else begin
          state_next = S_DEC_MUL;
        end
      end
      S_PRE_LEAD: begin
        cmd.emit   = EM_LEAD;
        state_next = S_PRE_MARK;
      end
      S_PRE_MARK: begin
        cmd.emit   = EM_MARK;
        state_next = S_DIGITS;
      end
      S_DIGITS: begin
        cmd.emit = EM_DIGIT;
        if (sts.cnt_one) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/i2af_dpath.sv
// Datapath of the integer to ASCII formatter: digit extraction and result register.
`default_nettype none
module i2af_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire i2af_pkg::req_t req,
  input  wire i2af_pkg::cmd_t cmd,
  output i2af_pkg::sts_t      sts,
  output logic                strobe,
  output i2af_pkg::rsp_t      rsp
);
  import i2af_pkg::*;

  logic [63:0]       val;
  logic [63:0]       prod;
  op_t               op;
  logic              prefix;
  logic [CNT_W-1:0]  cnt;
  logic [3:0]        dig [DIG_DEPTH];

  logic              neg_in;
  logic [31:0]       mag_in;
  logic [QUOT_W-1:0] quot;
  logic [31:0]       quot_x10;
  logic [3:0]        rem;
  logic [3:0]        rd_dig;
  logic [7:0]        ch;
  logic              ch_last;

  // Decode the incoming request
  assign neg_in = (op_t'(req.opcode) == OP_SDEC) && req.value[31];
  assign mag_in = neg_in ? (32'd0 - req.value[31:0]) : req.value[31:0];

  // Quotient and remainder of one decimal step
  assign quot     = prod[63:RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = 4'(val[31:0] - quot_x10);

  // Status for the controller
  assign sts.hex_last = (val[63:4] == 60'd0);
  assign sts.dec_last = (quot == '0);
  assign sts.neg      = prefix;
  assign sts.cnt_one  = (cnt == CNT_W'(1));

  // Load the argument and run the digit steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_t'(req.opcode);
      prefix <= neg_in || (op_t'(req.opcode) == OP_PTR);
      val    <= (op_t'(req.opcode) == OP_PTR) ? req.value : {32'd0, mag_in};
      cnt    <= '0;
    end else if (cmd.hex_step) begin
      dig[cnt[DIG_IW-1:0]] <= val[3:0];
      val                  <= {4'd0, val[63:4]};
      cnt                  <= cnt + CNT_W'(1);
    end else if (cmd.dec_step) begin
      dig[cnt[DIG_IW-1:0]] <= rem;
      val                  <= {{(64 - QUOT_W){1'b0}}, quot};
      cnt                  <= cnt + CNT_W'(1);
    end else if (cmd.emit == EM_DIGIT) begin
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.mul_step) begin
      prod <= {32'd0, val[31:0]} * {32'd0, RECIP10};
    end
  end

  // Select the character of this cycle
  assign rd_dig = dig[cnt[DIG_IW-1:0] - DIG_IW'(1)];

  always_comb begin
    ch      = CH_ZERO;
    ch_last = 1'b0;
    case (cmd.emit)
      EM_SINGLE: begin
        ch      = (op == OP_CHAR) ? val[7:0] : CH_PERCENT;
        ch_last = 1'b1;
      end
      EM_LEAD: ch = CH_ZERO;
      EM_MARK: ch = (op == OP_PTR) ? CH_LOWER_X : CH_MINUS;
      EM_DIGIT: begin
        ch      = digit_char(rd_dig, op == OP_HEXU);
        ch_last = (cnt == CNT_W'(1));
      end
      default: ch = CH_ZERO;
    endcase
  end

  // Register the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EM_NONE);
    end
    rsp.out_char <= ch;
    rsp.last     <= ch_last;
  end

endmodule
`default_nettype wire

// File: hdl/integer_to_ascii_formatter_unit.sv
// Order: char and percent go from the single-character state to the result register;
// numbers wait until all digits are found (a hex step per hex digit, a multiply and a
// divide step per decimal digit). Throughput: one request at a time; a new request is
// accepted only in idle, after the digit extraction loop and the last character.
// Characters then leave one per cycle; the receiver cannot stall.
// Reset: synchronous, active high; clears the state machine and the strobe.
`default_nettype none
module integer_to_ascii_formatter_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire i2af_pkg::req_t req,
  output logic                strobe,
  output i2af_pkg::rsp_t      rsp
);
  import i2af_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the conversion
  i2af_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Extract digits and drive results
  i2af_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

// File: hdl/i2af_checker.sv
// Port-level assertions of the integer to ASCII formatter, bound to the top level.
`default_nettype none
module i2af_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           strobe,
  input wire i2af_pkg::rsp_t rsp
);
  import i2af_pkg::*;

  // Characters of one run come in consecutive cycles
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !rsp.last |=> strobe)
    else $error("result run broken before its last character");

  // A run in progress keeps the unit busy
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !rsp.last |-> busy)
    else $error("unit idle in the middle of a result run");

  // The last character is followed by a gap
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.last |=> !strobe)
    else $error("result transfer right after the last character");

  // No result transfer in the cycle after a request transfer
  a_quiet_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("result transfer right after a request transfer");

  // Reset leaves the unit idle and silent
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("unit not idle after reset");

endmodule

bind integer_to_ascii_formatter_unit i2af_checker u_i2af_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .rsp    (rsp)
);
`default_nettype wire
